// ===== rtl/core/pwl_pkg.sv =====
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared widths, field offsets, codes and controller/datapath bundles for the
// piecewise-linear curve evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pwl_pkg;

  localparam int DATA_W         = 32;
  localparam int IDX_IN_W       = 3;
  localparam int CNT_IN_W       = 4;
  localparam int DEF_MAX_POINTS = 8;

  // input tdata layout, lowest bit first
  localparam int IN_IDX_LSB     = 0;
  localparam int IN_PX_LSB      = IN_IDX_LSB + IDX_IN_W;
  localparam int IN_PY0_LSB     = IN_PX_LSB + DATA_W;
  localparam int IN_PY1_LSB     = IN_PY0_LSB + DATA_W;
  localparam int IN_SX_LSB      = IN_PY1_LSB + DATA_W;
  localparam int IN_USED_W      = IN_SX_LSB + DATA_W;
  localparam int IN_TDATA_W     = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W    = 2 * DATA_W;

  localparam int DIV_STEPS      = DATA_W;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  localparam logic CMD_EVAL     = 1'b0;
  localparam logic CMD_WRITE    = 1'b1;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_ZERO,
    RES_RD,
    RES_HI,
    RES_ARITH
  } res_sel_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] second;
    logic signed [DATA_W-1:0] first;
    logic signed [DATA_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic     accept;
    logic     tbl_wr;
    logic     ld_lo;
    logic     ld_hi;
    res_sel_t res_sel;
    logic     diff;
    logic     mul;
    logic     div_step;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic x_le_rd;
    logic x_ge_hi;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/pwl_datapath.sv =====
// ----------------------------------------------------------------------------
// pwl_datapath
// Point table, segment registers, two multiply/serial-divide lanes, result
// and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_datapath import pwl_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int IDX_W      = $clog2(MAX_POINTS)
) (
  input  wire logic                   clk,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire dp_cmd_t                cmd,
  input  wire logic [IDX_W-1:0]       rd_addr,
  output dp_sts_t                     sts,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  point_t                    mem [MAX_POINTS];
  point_t                    rd_q_r;
  point_t                    lo_r;
  point_t                    hi_r;
  logic signed [DATA_W-1:0]  x_r;

  logic [DATA_W-1:0]         dx_r;
  logic [DATA_W-1:0]         den_r;
  logic [DATA_W-1:0]         mag_r  [2];
  logic                      neg_r  [2];
  logic [DATA_W-1:0]         rem_r  [2];
  logic [DATA_W-1:0]         pq_r   [2];
  logic signed [DATA_W-1:0]  res_r  [2];
  logic signed [DATA_W-1:0]  out_r  [2];

  logic [IDX_IN_W-1:0]       in_idx;
  point_t                    in_pt;
  logic                      idx_ok;

  logic signed [DATA_W:0]    dy     [2];
  logic [DATA_W:0]           dy_abs [2];
  logic [2*DATA_W-1:0]       prod   [2];
  logic [DATA_W:0]           trial  [2];
  logic                      ge     [2];
  logic signed [DATA_W-1:0]  y_lo   [2];
  logic signed [DATA_W-1:0]  y_hi   [2];
  logic signed [DATA_W-1:0]  y_rd   [2];
  logic signed [DATA_W-1:0]  y_add  [2];

  assign in_idx       = in_tdata[IN_IDX_LSB +: IDX_IN_W];
  assign in_pt.x      = in_tdata[IN_PX_LSB  +: DATA_W];
  assign in_pt.first  = in_tdata[IN_PY0_LSB +: DATA_W];
  assign in_pt.second = in_tdata[IN_PY1_LSB +: DATA_W];
  assign idx_ok       = (32'(in_idx) < 32'(MAX_POINTS));

  assign sts.x_le_rd  = (x_r <= rd_q_r.x);
  assign sts.x_ge_hi  = (x_r >= hi_r.x);

  assign y_lo[0] = lo_r.first;
  assign y_lo[1] = lo_r.second;
  assign y_hi[0] = hi_r.first;
  assign y_hi[1] = hi_r.second;
  assign y_rd[0] = rd_q_r.first;
  assign y_rd[1] = rd_q_r.second;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dy[l]     = {y_hi[l][DATA_W-1], y_hi[l]} - {y_lo[l][DATA_W-1], y_lo[l]};
      dy_abs[l] = dy[l][DATA_W] ? (~dy[l] + 1'b1) : dy[l];
      prod[l]   = mag_r[l] * dx_r;
      trial[l]  = {rem_r[l], pq_r[l][DATA_W-1]};
      ge[l]     = (trial[l] >= {1'b0, den_r});
      y_add[l]  = neg_r[l] ? (y_lo[l] - pq_r[l]) : (y_lo[l] + pq_r[l]);
    end
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && idx_ok) begin
      mem[IDX_W'(in_idx)] <= in_pt;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r <= in_tdata[IN_SX_LSB +: DATA_W];
    end
    if (cmd.ld_lo) begin
      lo_r <= rd_q_r;
    end
    if (cmd.ld_hi) begin
      hi_r <= rd_q_r;
    end
    if (cmd.diff) begin
      dx_r  <= DATA_W'({x_r[DATA_W-1], x_r} - {lo_r.x[DATA_W-1], lo_r.x});
      den_r <= DATA_W'({hi_r.x[DATA_W-1], hi_r.x} - {lo_r.x[DATA_W-1], lo_r.x});
    end
    for (int l = 0; l < 2; l++) begin
      if (cmd.diff) begin
        mag_r[l] <= dy_abs[l][DATA_W-1:0];
        neg_r[l] <= dy[l][DATA_W];
      end
      if (cmd.mul) begin
        rem_r[l] <= prod[l][2*DATA_W-1:DATA_W];
        pq_r[l]  <= prod[l][DATA_W-1:0];
      end else if (cmd.div_step) begin
        rem_r[l] <= ge[l] ? DATA_W'(trial[l] - {1'b0, den_r}) : trial[l][DATA_W-1:0];
        pq_r[l]  <= {pq_r[l][DATA_W-2:0], ge[l]};
      end
      case (cmd.res_sel)
        RES_ZERO:  res_r[l] <= '0;
        RES_RD:    res_r[l] <= y_rd[l];
        RES_HI:    res_r[l] <= y_hi[l];
        RES_ARITH: res_r[l] <= y_add[l];
        default:   res_r[l] <= res_r[l];
      endcase
      if (cmd.out_load) begin
        out_r[l] <= res_r[l];
      end
    end
  end

  assign out_tdata = {out_r[1], out_r[0]};

endmodule

`default_nettype wire

// ===== rtl/core/pwl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pwl_ctrl
// Sequencer: point count register, table scan, divide step count and
// output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_ctrl import pwl_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int IDX_W      = $clog2(MAX_POINTS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CNT_IN_W-1:0]  cfg_wdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic                 in_tuser,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire dp_sts_t              sts,
  output dp_cmd_t                   cmd,
  output logic [IDX_W-1:0]          rd_addr
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LAST,
    S_RD_FIRST,
    S_SCAN,
    S_DIFF,
    S_MUL,
    S_DIV,
    S_ADD,
    S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_IN_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]      j_r, j_nxt;
  logic [DIV_CNT_W-1:0]  step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]      last_idx;

  assign last_idx = (32'(count_r) >= 32'(MAX_POINTS)) ? IDX_W'(MAX_POINTS - 1)
                                                      : IDX_W'(count_r - 1'b1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = cfg_we ? cfg_wdata : count_r;
    j_nxt         = j_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd           = '0;
    cmd.res_sel   = RES_HOLD;
    rd_addr       = j_r;
    in_tready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (in_tuser == CMD_WRITE) begin
            cmd.tbl_wr = 1'b1;
          end else if (count_r == '0) begin
            cmd.res_sel = RES_ZERO;
            state_nxt   = S_DONE;
          end else begin
            rd_addr   = last_idx;
            state_nxt = S_RD_LAST;
          end
        end
      end
      S_RD_LAST: begin
        cmd.ld_hi = 1'b1;
        rd_addr   = '0;
        state_nxt = S_RD_FIRST;
      end
      S_RD_FIRST: begin
        if (sts.x_le_rd) begin
          cmd.res_sel = RES_RD;
          state_nxt   = S_DONE;
        end else if (sts.x_ge_hi) begin
          cmd.res_sel = RES_HI;
          state_nxt   = S_DONE;
        end else begin
          cmd.ld_lo = 1'b1;
          j_nxt     = IDX_W'(1);
          rd_addr   = IDX_W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.x_le_rd) begin
          cmd.ld_hi = 1'b1;
          state_nxt = S_DIFF;
        end else begin
          cmd.ld_lo = 1'b1;
          j_nxt     = j_r + 1'b1;
          rd_addr   = j_r + 1'b1;
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.res_sel = RES_ARITH;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      j_r         <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      j_r         <= j_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/piecewise_linear_curve_eval_top.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_curve_eval_top
// Two-channel piecewise-linear curve evaluator over a shared x axis.
//
// Input stream: tuser selects the transaction kind (evaluate or point write).
// A point write stores x and both y values in one table entry and produces
// no output; the controller stays idle for it. An evaluate transaction returns
// one output transaction carrying both interpolated values.
// An evaluate with no points set returns zero; a sample at or below the first
// point's x returns the first point's values, one at or above the last point's
// x returns the last point's values. Otherwise the segment scan reads one entry
// per cycle from the single table port, and the restoring divider then makes
// one quotient bit per cycle for both channels in parallel.
// One evaluate is in flight at a time: the next transaction can be accepted
// in the cycle in which out_tvalid rises; writes run back to back.
// The output register holds a finished result while the receiver stalls;
// the next item is still accepted and its result waits for the slot.
// Reset clears point_count to zero and empties the output; table contents
// are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_curve_eval_top import pwl_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CNT_IN_W-1:0]     cfg_wdata,   // point_count
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // point_index, point_x, point_first_value, point_second_value, sample_x
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                    in_tuser,    // command
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata    // first_result, second_result
);

  localparam int IDX_W = $clog2(MAX_POINTS);

  dp_cmd_t           dp_cmd;
  dp_sts_t           dp_sts;
  logic [IDX_W-1:0]  rd_addr;

  pwl_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (dp_sts),
    .cmd        (dp_cmd),
    .rd_addr    (rd_addr)
  );

  pwl_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .IDX_W      (IDX_W)
  ) u_datapath (
    .clk        (clk),
    .in_tdata   (in_tdata),
    .cmd        (dp_cmd),
    .rd_addr    (rd_addr),
    .sts        (dp_sts),
    .out_tdata  (out_tdata)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("output register loaded while holding an undelivered result");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == CMD_EVAL) |=> !in_tready)
    else $error("input accepted while an evaluate is in progress");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |=> out_tvalid)
    else $error("loaded result not presented");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.div_step |-> (!in_tready && !dp_cmd.out_load))
    else $error("divider stepping outside the compute phase");

endmodule

`default_nettype wire
